// ===== hw/rtl/tvm_pkg.sv =====
// shared constants and the arctangent table for the thrust vector mixer
// no dependencies
package tvm_pkg;

  // sqrt3 with 16 fraction bits
  localparam int SQRT3_Q16 = 113512;
  // inverse cordic gain, also folds in the divide by three
  localparam logic [29:0] GAIN_FIX = 30'd869377165;
  // split point of the magnitude for the gain multiply
  localparam int LO_BITS = 26;
  // fraction bits of the angle accumulator
  localparam int ANG_FRAC = 20;
  // angle accumulator width
  localparam int ZW = 23;
  // arctangent table length
  localparam int TABLE_LEN = 24;

  typedef logic signed [ZW-1:0] angle_t;

  // round(atan(2^-i)/pi * 2^20)
  function automatic angle_t atan_entry(input int unsigned i);
    angle_t r;
    case (i)
      0:       r = 23'sd262144;
      1:       r = 23'sd154753;
      2:       r = 23'sd81767;
      3:       r = 23'sd41506;
      4:       r = 23'sd20834;
      5:       r = 23'sd10427;
      6:       r = 23'sd5215;
      7:       r = 23'sd2608;
      8:       r = 23'sd1304;
      9:       r = 23'sd652;
      10:      r = 23'sd326;
      11:      r = 23'sd163;
      12:      r = 23'sd81;
      13:      r = 23'sd41;
      14:      r = 23'sd20;
      15:      r = 23'sd10;
      16:      r = 23'sd5;
      17:      r = 23'sd3;
      18:      r = 23'sd1;
      19:      r = 23'sd1;
      default: r = 23'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/tvm_mixer.sv =====
// mixing matrix stage: three vertical and three tilt parts, scaled by three
// depends on tvm_pkg
module tvm_mixer #(
  parameter int DW = 16,
  parameter int MW = DW + 18
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [DW-1:0] force_x,
  input  logic signed [DW-1:0] force_y,
  input  logic signed [DW-1:0] force_z,
  input  logic signed [DW-1:0] torque_x,
  input  logic signed [DW-1:0] torque_y,
  input  logic signed [DW-1:0] torque_z,
  output logic signed [MW-1:0] vert [3],
  output logic signed [MW-1:0] tilt [3]
);
  import tvm_pkg::*;

  localparam logic signed [MW-1:0] K3 = MW'(SQRT3_Q16);

  logic signed [MW-1:0] fx, fy, fz, cx, cy, cz;
  logic signed [MW-1:0] px, pc, vs, ts;

  // widen inputs
  assign fx = MW'(force_x);
  assign fy = MW'(force_y);
  assign fz = MW'(force_z);
  assign cx = MW'(torque_x);
  assign cy = MW'(torque_y);
  assign cz = MW'(torque_z);

  // sqrt3 products and shared sums
  assign px = fx * K3;
  assign pc = cx * K3;
  assign vs = (fz - cy) <<< 16;
  assign ts = (cz - fy) <<< 16;

  // matrix rows
  always_ff @(posedge clk) begin
    if (en) begin
      vert[0] <= (fz + (cy <<< 1)) <<< 16;
      vert[1] <= vs - pc;
      vert[2] <= vs + pc;
      tilt[0] <= ((fy <<< 1) + cz) <<< 16;
      tilt[1] <= ts - px;
      tilt[2] <= ts + px;
    end
  end

endmodule

// ===== hw/rtl/tvm_cordic.sv =====
// pipelined vectoring cordic: quarter-turn pre-rotation then one stage per register
// depends on tvm_pkg
module tvm_cordic #(
  parameter int DW = 16,
  parameter int N  = 16,
  parameter int MW = DW + 18,
  parameter int W  = DW + 20
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MW-1:0]      x_in,
  input  logic signed [MW-1:0]      y_in,
  output logic signed [W-1:0]       x_out,
  output tvm_pkg::angle_t           z_out,
  output logic                      zero_out
);
  import tvm_pkg::*;

  logic signed [W-1:0] x [0:N];
  logic signed [W-1:0] y [0:N];
  angle_t              z [0:N];
  logic                zero [0:N];
  logic signed [W-1:0] xw, yw;

  assign xw = W'(x_in);
  assign yw = W'(y_in);

  // pre-rotation of left-half vectors
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x_in == '0) && (y_in == '0);
      if (xw[W-1]) begin
        if (!yw[W-1]) begin
          x[0] <= yw;
          y[0] <= -xw;
          z[0] <= atan_entry(0) <<< 1;
        end else begin
          x[0] <= -yw;
          y[0] <= xw;
          z[0] <= -(atan_entry(0) <<< 1);
        end
      end else begin
        x[0] <= xw;
        y[0] <= yw;
        z[0] <= '0;
      end
    end
  end

  // rotation stages toward the x axis
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] dx, dy;
    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (!y[i][W-1]) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
          z[i+1] <= z[i] + atan_entry(i);
        end else begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
          z[i+1] <= z[i] - atan_entry(i);
        end
      end
    end
  end

  assign x_out    = x[N];
  assign z_out    = z[N];
  assign zero_out = zero[N];

endmodule

// ===== hw/rtl/tvm_post.sv =====
// gain correction, angle rounding and saturation, two register stages
// depends on tvm_pkg
module tvm_post #(
  parameter int DW = 16,
  parameter int W  = DW + 20
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  x_in,
  input  tvm_pkg::angle_t      z_in,
  input  logic                 zero_in,
  output logic [DW-1:0]        thrust,
  output logic signed [DW-1:0] tilt
);
  import tvm_pkg::*;

  localparam int HW = W - LO_BITS;
  localparam int PW = HW + 31;
  localparam int RW = ZW + DW;
  localparam int FB = DW - 1;
  localparam logic signed [RW-1:0] ONE  = 1;
  localparam logic signed [RW-1:0] TMAX = (ONE <<< (DW - 1)) - ONE;
  localparam logic signed [RW-1:0] TMIN = -(ONE <<< (DW - 1));

  logic [HW-1:0]          hi;
  logic [LO_BITS-1:0]     lo;
  logic [PW-1:0]          ph;
  logic [LO_BITS+29:0]    pl;
  logic signed [RW-1:0]   zr, rnd;
  logic signed [RW-1:0]   r;
  logic                   zero;
  logic [PW-1:0]          tsum;
  logic [PW-23:0]         tq;

  assign hi = x_in[W-1:LO_BITS];
  assign lo = x_in[LO_BITS-1:0];
  assign zr = RW'(z_in);

  // angle scaling to the output fraction bits
  if (FB <= ANG_FRAC) begin : g_down
    if (FB < ANG_FRAC) begin : g_round
      assign rnd = (zr + (ONE <<< (ANG_FRAC - FB - 1))) >>> (ANG_FRAC - FB);
    end else begin : g_same
      assign rnd = zr;
    end
  end else begin : g_up
    assign rnd = zr <<< (FB - ANG_FRAC);
  end

  // gain multiplies
  always_ff @(posedge clk) begin
    if (en) begin
      ph   <= PW'(hi) * PW'(GAIN_FIX);
      pl   <= (LO_BITS + 30)'(lo) * (LO_BITS + 30)'(GAIN_FIX);
      r    <= rnd;
      zero <= zero_in;
    end
  end

  // rounding and saturation
  assign tsum = ph + PW'(1 << 21) + PW'(pl >> LO_BITS);
  assign tq   = tsum[PW-1:22];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero) begin
        thrust <= '0;
        tilt   <= '0;
      end else begin
        thrust <= (tq[PW-23:DW] != '0) ? '1 : tq[DW-1:0];
        if (r > TMAX) tilt <= TMAX[DW-1:0];
        else if (r < TMIN) tilt <= TMIN[DW-1:0];
        else tilt <= r[DW-1:0];
      end
    end
  end

endmodule

// ===== hw/rtl/trirotor_thrust_vector_mixer.sv =====
// Trirotor thrust vector mixer: one force/torque request in, per-rotor thrust and tilt out.
// Fully pipelined: one request per cycle unless a stalled result is held. Registers:
// mixer, pre-rotation, one per CORDIC stage, gain multiply, saturation. A stall on the
// output while a result waits there freezes the whole pipeline and is passed straight back
// as in_stall; with no result waiting, a stall is ignored and the pipeline keeps advancing.
// depends on tvm_pkg, tvm_mixer, tvm_cordic, tvm_post
module trirotor_thrust_vector_mixer #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] force_x,
  input  logic signed [DATA_WIDTH-1:0] force_y,
  input  logic signed [DATA_WIDTH-1:0] force_z,
  input  logic signed [DATA_WIDTH-1:0] torque_x,
  input  logic signed [DATA_WIDTH-1:0] torque_y,
  input  logic signed [DATA_WIDTH-1:0] torque_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [DATA_WIDTH-1:0]        thrust_1,
  output logic [DATA_WIDTH-1:0]        thrust_2,
  output logic [DATA_WIDTH-1:0]        thrust_3,
  output logic signed [DATA_WIDTH-1:0] tilt_1,
  output logic signed [DATA_WIDTH-1:0] tilt_2,
  output logic signed [DATA_WIDTH-1:0] tilt_3
);
  import tvm_pkg::*;

  localparam int MW  = DATA_WIDTH + 18;
  localparam int W   = DATA_WIDTH + 20;
  localparam int LAT = CORDIC_STAGES + 4;

  logic                  en;
  logic [LAT-1:0]        vld;
  logic signed [MW-1:0]  vert [3];
  logic signed [MW-1:0]  tlt [3];
  logic signed [W-1:0]   xr [3];
  angle_t                zr [3];
  logic                  zf [3];
  logic [DATA_WIDTH-1:0] thr [3];
  logic signed [DATA_WIDTH-1:0] ang [3];

  // pipeline advances unless the output holds a stalled result
  assign en       = !(vld[LAT-1] && out_stall);
  assign in_stall = !en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  tvm_mixer #(.DW(DATA_WIDTH), .MW(MW)) u_mixer (
    .clk(clk), .en(en),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .torque_x(torque_x), .torque_y(torque_y), .torque_z(torque_z),
    .vert(vert), .tilt(tlt)
  );

  // one cordic and post stage per rotor
  for (genvar k = 0; k < 3; k++) begin : g_rotor
    tvm_cordic #(.DW(DATA_WIDTH), .N(CORDIC_STAGES), .MW(MW), .W(W)) u_cordic (
      .clk(clk), .en(en), .x_in(tlt[k]), .y_in(vert[k]),
      .x_out(xr[k]), .z_out(zr[k]), .zero_out(zf[k])
    );
    tvm_post #(.DW(DATA_WIDTH), .W(W)) u_post (
      .clk(clk), .en(en), .x_in(xr[k]), .z_in(zr[k]), .zero_in(zf[k]),
      .thrust(thr[k]), .tilt(ang[k])
    );
  end

  assign out_valid = vld[LAT-1];
  assign thrust_1  = thr[0];
  assign thrust_2  = thr[1];
  assign thrust_3  = thr[2];
  assign tilt_1    = ang[0];
  assign tilt_2    = ang[1];
  assign tilt_3    = ang[2];

endmodule

// ===== hw/rtl/tvm_checker.sv =====
// port-level checks for the thrust vector mixer, bound to the top level
// depends on trirotor_thrust_vector_mixer
module tvm_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [DATA_WIDTH-1:0] thrust_1,
  input logic [DATA_WIDTH-1:0] tilt_1
);

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(thrust_1) && $stable(tilt_1))
    else $error("stalled result changed");

  // backpressure reaches the input only from a held result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not match output hold");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind trirotor_thrust_vector_mixer tvm_checker #(.DATA_WIDTH(DATA_WIDTH)) u_tvm_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .thrust_1(thrust_1), .tilt_1(tilt_1)
);
